// ===== hw/rtl/brfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfp_pkg
// Types, constants and sine lookup for the one-bit surface power evaluator.
// ----------------------------------------------------------------------------
package brfp_pkg;

  localparam int ROWS       = 16;
  localparam int COLUMNS    = 16;
  localparam int PHASE_BITS = 16;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = $clog2(ROWS + 1);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROWS);

  localparam logic [15:0] PHASE_KEEP    = 16'(16'hFFFF << (16 - PHASE_BITS));
  localparam logic [15:0] QUARTER_TURN  = 16'd16384;
  localparam logic [47:0] POWER_MAX     = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REG_PHASE_X = 2'd0,
    REG_PHASE_Y = 2'd1,
    REG_GAIN_M  = 2'd2,
    REG_GAIN_SH = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_DRAIN,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [15:0] row_bits;
    logic        last_row;
    logic [15:0] pattern_id;
  } in_t;

  typedef struct packed {
    logic [47:0] power;
    logic [15:0] best_id;
    logic [47:0] best_power;
    logic [15:0] worst_id;
    logic [47:0] worst_power;
    logic        too_many_rows;
  } out_t;

  function automatic logic [14:0] quarter_sine(logic [5:0] k);
    logic [14:0] v;
    case (k)
      6'd0:  v = 15'd0;
      6'd1:  v = 15'd804;
      6'd2:  v = 15'd1606;
      6'd3:  v = 15'd2404;
      6'd4:  v = 15'd3196;
      6'd5:  v = 15'd3981;
      6'd6:  v = 15'd4756;
      6'd7:  v = 15'd5520;
      6'd8:  v = 15'd6270;
      6'd9:  v = 15'd7005;
      6'd10: v = 15'd7723;
      6'd11: v = 15'd8423;
      6'd12: v = 15'd9102;
      6'd13: v = 15'd9760;
      6'd14: v = 15'd10394;
      6'd15: v = 15'd11003;
      6'd16: v = 15'd11585;
      6'd17: v = 15'd12140;
      6'd18: v = 15'd12665;
      6'd19: v = 15'd13160;
      6'd20: v = 15'd13623;
      6'd21: v = 15'd14053;
      6'd22: v = 15'd14449;
      6'd23: v = 15'd14811;
      6'd24: v = 15'd15137;
      6'd25: v = 15'd15426;
      6'd26: v = 15'd15679;
      6'd27: v = 15'd15893;
      6'd28: v = 15'd16069;
      6'd29: v = 15'd16207;
      6'd30: v = 15'd16305;
      6'd31: v = 15'd16364;
      6'd32: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // u is the in-quadrant phase, 0..16384
  function automatic logic [14:0] quarter_lookup(logic [14:0] u);
    logic [5:0]  idx;
    logic [8:0]  frac;
    logic [14:0] a;
    logic [14:0] b;
    logic [9:0]  diff;
    logic [19:0] prod;
    logic [14:0] v;
    idx  = {1'b0, u[13:9]};
    frac = u[8:0];
    a    = quarter_sine(idx);
    b    = quarter_sine(idx + 6'd1);
    diff = 10'(b - a);
    prod = 20'(diff * frac) + 20'd256;
    v    = a + 15'(prod[19:9]);
    if (u[14]) begin
      v = 15'd16384;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] sine16(logic [15:0] ph);
    logic [14:0] r;
    logic [14:0] u;
    logic [15:0] v;
    r = {1'b0, ph[13:0]};
    u = ph[14] ? 15'(15'd16384 - r) : r;
    v = {1'b0, quarter_lookup(u)};
    return ph[15] ? 16'(-v) : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/binary_ris_farfield_power_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_ris_farfield_power_core
// Far-field power of one-bit surface patterns, one row of element bits per
// transfer, with best and worst pattern tracking.
// ----------------------------------------------------------------------------
// a row runs one element a cycle through the sine lookup, then the drain
// state adds the last element; a row past ROWS is not summed and sets ovf_r
// a last row then squares the sums and applies the gain on the shared 32x32 multiplier
// a new row is taken only in idle; a result waits in the output register
// reset clears configuration (gain_mantissa to 1), accumulators and history
module binary_ris_farfield_power_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire brfp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output brfp_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  brfp_pkg::state_t state_r, state_nxt;

  logic [15:0] phase_x_r, phase_y_r;
  logic [31:0] gain_m_r;
  logic [5:0]  gain_sh_r;

  logic [15:0]                row_bits_r;
  logic                       last_r;
  logic [15:0]                id_r;
  logic [brfp_pkg::COL_W-1:0] col_r;
  logic [15:0]                phase_r;
  logic signed [15:0]         lk_re_r, lk_im_r;
  logic                       lk_v_r;
  logic signed [24:0]         sum_re_r, sum_im_r;
  logic [brfp_pkg::ROW_W-1:0] row_idx_r;
  logic                       ovf_r;
  logic                       have_r;
  logic [63:0]                mul_r;
  logic [46:0]                mag_r;
  logic [79:0]                prod_r;
  logic [47:0]                pw_r;
  logic [47:0]                best_pw_r, worst_pw_r;
  logic [15:0]                best_id_r, worst_id_r;
  logic                       out_valid_r;
  brfp_pkg::out_t             out_r;

  logic        in_fire, out_load, cfg_wr;
  logic [31:0] mul_a, mul_b;
  logic [15:0] start_ph, ph_m;
  logic signed [15:0] s_val, c_val;
  logic [23:0] re_abs, im_abs;
  logic [79:0] shifted;
  logic [47:0] pw_sat;
  logic        take_best, take_worst;
  logic [47:0] best_pw_nxt, worst_pw_nxt;
  logic [15:0] best_id_nxt, worst_id_nxt;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (brfp_pkg::reg_idx_t'(paddr[3:2]))
      brfp_pkg::REG_PHASE_X: prdata = {16'd0, phase_x_r};
      brfp_pkg::REG_PHASE_Y: prdata = {16'd0, phase_y_r};
      brfp_pkg::REG_GAIN_M:  prdata = gain_m_r;
      brfp_pkg::REG_GAIN_SH: prdata = {26'd0, gain_sh_r};
      default:               prdata = 32'd0;
    endcase
  end

  // element phase and lookup
  assign start_ph = 16'(phase_x_r + 16'(phase_y_r * {row_idx_r, 1'b1}));
  assign ph_m     = phase_r & brfp_pkg::PHASE_KEEP;
  assign s_val    = brfp_pkg::sine16(ph_m);
  assign c_val    = brfp_pkg::sine16(16'(ph_m + brfp_pkg::QUARTER_TURN));

  assign re_abs = sum_re_r[24] ? 24'(-sum_re_r) : sum_re_r[23:0];
  assign im_abs = sum_im_r[24] ? 24'(-sum_im_r) : sum_im_r[23:0];

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      brfp_pkg::ST_SQ_RE: begin
        mul_a = {8'd0, re_abs};
        mul_b = {8'd0, re_abs};
      end
      brfp_pkg::ST_SQ_IM: begin
        mul_a = {8'd0, im_abs};
        mul_b = {8'd0, im_abs};
      end
      brfp_pkg::ST_MUL_LO: begin
        mul_a = mag_r[31:0];
        mul_b = gain_m_r;
      end
      brfp_pkg::ST_MUL_HI: begin
        mul_a = {17'd0, mag_r[46:32]};
        mul_b = gain_m_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign shifted = prod_r >> gain_sh_r;
  assign pw_sat  = (|shifted[79:48]) ? brfp_pkg::POWER_MAX : shifted[47:0];

  assign take_best  = !have_r || (pw_r > best_pw_r);
  assign take_worst = !have_r || (pw_r < worst_pw_r);
  assign best_pw_nxt  = take_best  ? pw_r : best_pw_r;
  assign best_id_nxt  = take_best  ? id_r : best_id_r;
  assign worst_pw_nxt = take_worst ? pw_r : worst_pw_r;
  assign worst_id_nxt = take_worst ? id_r : worst_id_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brfp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      brfp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (row_idx_r >= brfp_pkg::ROW_MAX) begin
            state_nxt = in_data.last_row ? brfp_pkg::ST_SQ_RE : brfp_pkg::ST_IDLE;
          end else begin
            state_nxt = brfp_pkg::ST_ROW;
          end
        end
      end
      brfp_pkg::ST_ROW: begin
        if (col_r == brfp_pkg::COL_LAST) begin
          state_nxt = brfp_pkg::ST_DRAIN;
        end
      end
      brfp_pkg::ST_DRAIN: begin
        state_nxt = last_r ? brfp_pkg::ST_SQ_RE : brfp_pkg::ST_IDLE;
      end
      brfp_pkg::ST_SQ_RE:  state_nxt = brfp_pkg::ST_SQ_IM;
      brfp_pkg::ST_SQ_IM:  state_nxt = brfp_pkg::ST_MAG;
      brfp_pkg::ST_MAG:    state_nxt = brfp_pkg::ST_MUL_LO;
      brfp_pkg::ST_MUL_LO: state_nxt = brfp_pkg::ST_MUL_HI;
      brfp_pkg::ST_MUL_HI: state_nxt = brfp_pkg::ST_ADD_HI;
      brfp_pkg::ST_ADD_HI: state_nxt = brfp_pkg::ST_SHIFT;
      brfp_pkg::ST_SHIFT:  state_nxt = brfp_pkg::ST_RESULT;
      brfp_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = brfp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brfp_pkg::ST_IDLE;
    endcase
  end

  // datapath payload
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state_r)
      brfp_pkg::ST_IDLE: begin
        if (in_fire) begin
          row_bits_r <= in_data.row_bits;
          last_r     <= in_data.last_row;
          id_r       <= in_data.pattern_id;
          col_r      <= '0;
          phase_r    <= start_ph;
        end
      end
      brfp_pkg::ST_ROW: begin
        lk_re_r <= row_bits_r[col_r] ? 16'(-c_val) : c_val;
        lk_im_r <= row_bits_r[col_r] ? 16'(-s_val) : s_val;
        phase_r <= 16'(phase_r + {phase_x_r[14:0], 1'b0});
        col_r   <= col_r + 1'b1;
      end
      brfp_pkg::ST_SQ_IM:  mag_r  <= mul_r[46:0];
      brfp_pkg::ST_MAG:    mag_r  <= 47'(mag_r + mul_r[46:0]);
      brfp_pkg::ST_MUL_HI: prod_r <= {16'd0, mul_r};
      brfp_pkg::ST_ADD_HI: prod_r <= 80'(prod_r + {mul_r[47:0], 32'd0});
      brfp_pkg::ST_SHIFT:  pw_r   <= pw_sat;
      brfp_pkg::ST_RESULT: begin
        if (out_load) begin
          out_r.power         <= pw_r;
          out_r.best_id       <= best_id_nxt;
          out_r.best_power    <= best_pw_nxt;
          out_r.worst_id      <= worst_id_nxt;
          out_r.worst_power   <= worst_pw_nxt;
          out_r.too_many_rows <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control, accumulators and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_x_r   <= '0;
      phase_y_r   <= '0;
      gain_m_r    <= 32'd1;
      gain_sh_r   <= '0;
      lk_v_r      <= 1'b0;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      row_idx_r   <= '0;
      ovf_r       <= 1'b0;
      have_r      <= 1'b0;
      best_pw_r   <= '0;
      best_id_r   <= '0;
      worst_pw_r  <= '0;
      worst_id_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (brfp_pkg::reg_idx_t'(paddr[3:2]))
          brfp_pkg::REG_PHASE_X: phase_x_r <= pwdata[15:0];
          brfp_pkg::REG_PHASE_Y: phase_y_r <= pwdata[15:0];
          brfp_pkg::REG_GAIN_M:  gain_m_r  <= pwdata;
          brfp_pkg::REG_GAIN_SH: gain_sh_r <= pwdata[5:0];
          default: begin
          end
        endcase
      end

      lk_v_r <= (state_r == brfp_pkg::ST_ROW);
      if (lk_v_r) begin
        sum_re_r <= 25'(sum_re_r + {{9{lk_re_r[15]}}, lk_re_r});
        sum_im_r <= 25'(sum_im_r + {{9{lk_im_r[15]}}, lk_im_r});
      end

      if (in_fire && (row_idx_r >= brfp_pkg::ROW_MAX)) begin
        ovf_r <= 1'b1;
      end
      if (state_r == brfp_pkg::ST_DRAIN) begin
        row_idx_r <= row_idx_r + 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        have_r      <= 1'b1;
        best_pw_r   <= best_pw_nxt;
        best_id_r   <= best_id_nxt;
        worst_pw_r  <= worst_pw_nxt;
        worst_id_r  <= worst_id_nxt;
        sum_re_r    <= '0;
        sum_im_r    <= '0;
        row_idx_r   <= '0;
        ovf_r       <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
